// ===== src/rtpc_pkg.sv =====
// Shared types, constants and the sequencer microprogram of the ray/triangle parity counter.
package rtpc_pkg;

  // Coordinate and fixed-point formats
  localparam int CW         = 32;           // vertex / ray coordinate width
  localparam int COORD_FRAC = 16;           // fraction bits of coordinates and t
  localparam int BARY_FRAC  = 30;           // fraction bits of the edge margin
  localparam int QW         = 31;           // hit_distance width
  localparam int W          = 136;          // datapath width, holds every exact product
  localparam int HQW        = 68;           // width of the cross-product components
  localparam int SW         = 36;           // multiplier operand, 33 bits sign-extended
  localparam int DIG        = SW / 4;       // radix-16 digits per product
  localparam int DCW        = $clog2(DIG);
  localparam int QCW        = $clog2(QW);
  localparam int NPROG      = 37;
  localparam int PCW        = $clog2(NPROG);

  typedef logic signed [W-1:0]   wide_t;
  typedef logic signed [SW-1:0]  small_t;
  typedef logic signed [HQW-1:0] hq_t;
  typedef logic signed [CW:0]    ediff_t;
  typedef logic signed [4:0]     digit_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    R_ORIGIN_X, R_ORIGIN_Y, R_ORIGIN_Z, R_DIR_X, R_DIR_Y, R_DIR_Z,
    R_RAY_LIMIT, R_EDGE_MARGIN
  } reg_t;

  typedef enum logic [2:0] {
    OP_MAC, OP_ADD, OP_ABS, OP_DINIT, OP_DIV, OP_END
  } op_t;

  // Multiplier (narrow) operand
  typedef enum logic [3:0] {
    S_E1X, S_E1Y, S_E1Z, S_E2X, S_E2Y, S_E2Z,
    S_SX, S_SY, S_SZ, S_DX, S_DY, S_DZ, S_MAXD, S_MARG
  } ssel_t;

  // Wide operand
  typedef enum logic [4:0] {
    W_ZERO, W_E1X, W_E1Y, W_E1Z, W_E2X, W_E2Y, W_E2Z,
    W_H0, W_H1, W_H2, W_Q0, W_Q1, W_Q2,
    W_A, W_NU, W_NV, W_NT, W_UV, W_MDA, W_MA,
    W_NT16, W_NU30, W_NV30, W_AU30, W_NUM, W_DV
  } wsel_t;

  // Result destination; the F_ ones keep only the sign of the result
  typedef enum logic [4:0] {
    D_NONE, D_H0, D_H1, D_H2, D_Q0, D_Q1, D_Q2,
    D_A, D_NU, D_NV, D_NT, D_UV, D_AU, D_MDA, D_MA,
    D_FANU, D_FT, D_FNU, D_FNV, D_FAU
  } dst_t;

  typedef struct packed {
    op_t   op;
    logic  clr;   // start a fresh sum
    logic  sub;   // subtract this term
    logic  fix;   // also flip the term when the determinant was negative
    ssel_t ss;
    wsel_t xs;
    wsel_t ys;
    dst_t  dst;
  } uop_t;

  typedef struct packed {
    logic mac;
    logic sub;
  } unit_ctl_t;

  function automatic uop_t mac_op(input ssel_t s, input wsel_t y, input logic clr,
                                  input logic sub, input logic fix, input dst_t d);
    uop_t u;
    u = '{op: OP_MAC, clr: clr, sub: sub, fix: fix, ss: s, xs: W_ZERO, ys: y, dst: d};
    return u;
  endfunction

  function automatic uop_t add_op(input op_t op, input wsel_t x, input wsel_t y,
                                  input logic sub, input dst_t d);
    uop_t u;
    u = '{op: op, clr: 1'b0, sub: sub, fix: 1'b0, ss: S_E1X, xs: x, ys: y, dst: d};
    return u;
  endfunction

  // Microprogram: h = d x e2, a = e1.h, |a|, q = s x e1, nu/nv/nt, checks, divide
  function automatic uop_t prog(input logic [PCW-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mac_op(S_DY,  W_E2Z, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd1:  u = mac_op(S_DZ,  W_E2Y, 1'b0, 1'b1, 1'b0, D_H0);
      6'd2:  u = mac_op(S_DZ,  W_E2X, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd3:  u = mac_op(S_DX,  W_E2Z, 1'b0, 1'b1, 1'b0, D_H1);
      6'd4:  u = mac_op(S_DX,  W_E2Y, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd5:  u = mac_op(S_DY,  W_E2X, 1'b0, 1'b1, 1'b0, D_H2);
      6'd6:  u = mac_op(S_E1X, W_H0,  1'b1, 1'b0, 1'b0, D_NONE);
      6'd7:  u = mac_op(S_E1Y, W_H1,  1'b0, 1'b0, 1'b0, D_NONE);
      6'd8:  u = mac_op(S_E1Z, W_H2,  1'b0, 1'b0, 1'b0, D_A);
      6'd9:  u = add_op(OP_ABS, W_ZERO, W_A, 1'b1, D_A);
      6'd10: u = mac_op(S_SY,  W_E1Z, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd11: u = mac_op(S_SZ,  W_E1Y, 1'b0, 1'b1, 1'b0, D_Q0);
      6'd12: u = mac_op(S_SZ,  W_E1X, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd13: u = mac_op(S_SX,  W_E1Z, 1'b0, 1'b1, 1'b0, D_Q1);
      6'd14: u = mac_op(S_SX,  W_E1Y, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd15: u = mac_op(S_SY,  W_E1X, 1'b0, 1'b1, 1'b0, D_Q2);
      6'd16: u = mac_op(S_SX,  W_H0,  1'b1, 1'b0, 1'b1, D_NONE);
      6'd17: u = mac_op(S_SY,  W_H1,  1'b0, 1'b0, 1'b1, D_NONE);
      6'd18: u = mac_op(S_SZ,  W_H2,  1'b0, 1'b0, 1'b1, D_NU);
      6'd19: u = mac_op(S_DX,  W_Q0,  1'b1, 1'b0, 1'b1, D_NONE);
      6'd20: u = mac_op(S_DY,  W_Q1,  1'b0, 1'b0, 1'b1, D_NONE);
      6'd21: u = mac_op(S_DZ,  W_Q2,  1'b0, 1'b0, 1'b1, D_NV);
      6'd22: u = mac_op(S_E2X, W_Q0,  1'b1, 1'b0, 1'b1, D_NONE);
      6'd23: u = mac_op(S_E2Y, W_Q1,  1'b0, 1'b0, 1'b1, D_NONE);
      6'd24: u = mac_op(S_E2Z, W_Q2,  1'b0, 1'b0, 1'b1, D_NT);
      6'd25: u = add_op(OP_ADD, W_NU, W_NV, 1'b0, D_UV);
      6'd26: u = add_op(OP_ADD, W_A,  W_UV, 1'b1, D_AU);
      6'd27: u = add_op(OP_ADD, W_A,  W_NU, 1'b1, D_FANU);
      6'd28: u = mac_op(S_MAXD, W_A,  1'b1, 1'b0, 1'b0, D_MDA);
      6'd29: u = mac_op(S_MARG, W_A,  1'b1, 1'b0, 1'b0, D_MA);
      6'd30: u = add_op(OP_ADD, W_MDA,  W_NT16, 1'b1, D_FT);
      6'd31: u = add_op(OP_ADD, W_NU30, W_MA,   1'b1, D_FNU);
      6'd32: u = add_op(OP_ADD, W_NV30, W_MA,   1'b1, D_FNV);
      6'd33: u = add_op(OP_ADD, W_AU30, W_MA,   1'b1, D_FAU);
      6'd34: u = add_op(OP_DINIT, W_ZERO, W_ZERO, 1'b0, D_NONE);
      6'd35: u = add_op(OP_DIV, W_NUM, W_DV, 1'b1, D_NONE);
      default: u = add_op(OP_END, W_ZERO, W_ZERO, 1'b0, D_NONE);
    endcase
    return u;
  endfunction

endpackage

// ===== src/rtpc_unit.sv =====
// Shared arithmetic unit: one wide adder/subtractor fed by a radix-16 partial product.
module rtpc_unit (
  input  rtpc_pkg::unit_ctl_t ctl,
  input  rtpc_pkg::wide_t     x,
  input  rtpc_pkg::wide_t     y,
  input  rtpc_pkg::digit_t    digit,
  output rtpc_pkg::wide_t     res
);

  rtpc_pkg::wide_t prod;
  rtpc_pkg::wide_t yy;

  // multiplicand times one signed digit
  assign prod = y * digit;
  assign yy   = ctl.mac ? prod : y;

  // accumulate or plain add/subtract
  assign res = ctl.sub ? (x - yy) : (x + yy);

endmodule

// ===== src/ray_triangle_parity_counter.sv =====
// Top level of the ray/triangle crossing-parity counter.
//
//   channel   direction  handshake            contents
//   in        input      in_valid / in_stall  v0_x..v2_z, last_triangle
//   out       output     out_valid/out_stall  hit, hit_distance, near_edge,
//                                             inside_parity, edge_seen, is_last
//   cfg       input      cfg_write            cfg_index, cfg_data
//
// One triangle runs 26 products, each built one radix-16 digit at a time, through
// the shared adder/multiplier, then 7 add/compare steps and 31 restoring divide
// steps. in_stall is high from acceptance until the result is moved to the output
// register; a stalled output holds the finished item in the unit until the register
// frees up. Synchronous reset clears the control state and parity bits and loads
// the ray registers with their defaults.
module ray_triangle_parity_counter (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [rtpc_pkg::CW-1:0]        v0_x,
  input  logic signed [rtpc_pkg::CW-1:0]        v0_y,
  input  logic signed [rtpc_pkg::CW-1:0]        v0_z,
  input  logic signed [rtpc_pkg::CW-1:0]        v1_x,
  input  logic signed [rtpc_pkg::CW-1:0]        v1_y,
  input  logic signed [rtpc_pkg::CW-1:0]        v1_z,
  input  logic signed [rtpc_pkg::CW-1:0]        v2_x,
  input  logic signed [rtpc_pkg::CW-1:0]        v2_y,
  input  logic signed [rtpc_pkg::CW-1:0]        v2_z,
  input  logic                                  last_triangle,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  hit,
  output logic [rtpc_pkg::QW-1:0]               hit_distance,
  output logic                                  near_edge,
  output logic                                  inside_parity,
  output logic                                  edge_seen,
  output logic                                  is_last,
  input  logic                                  cfg_write,
  input  logic [2:0]                            cfg_index,
  input  logic [rtpc_pkg::CW-1:0]               cfg_data
);

  localparam int W  = rtpc_pkg::W;
  localparam int CW = rtpc_pkg::CW;
  localparam int QW = rtpc_pkg::QW;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t state;

  // ray configuration
  logic signed [CW-1:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
  logic [QW-1:0]        ray_limit, edge_margin;

  // captured triangle
  logic signed [CW-1:0] t0_x, t0_y, t0_z, t1_x, t1_y, t1_z, t2_x, t2_y, t2_z;
  logic                 last;

  // sequencer and datapath registers
  logic [rtpc_pkg::PCW-1:0] pc;
  logic [rtpc_pkg::DCW-1:0] dcnt;
  logic [rtpc_pkg::QCW-1:0] qcnt;
  rtpc_pkg::wide_t  acc, mc, det, nu, nv, nt, uv, au, mda, ma, num, dv;
  rtpc_pkg::small_t sm;
  rtpc_pkg::hq_t    h0, h1, h2, q0, q1, q2;
  logic [QW-1:0]    tq;
  logic             aneg, f_anu, f_t, f_nu, f_nv, f_au;
  logic             parity, edge_flag;

  rtpc_pkg::ediff_t e1_x, e1_y, e1_z, e2_x, e2_y, e2_z, s_x, s_y, s_z;
  rtpc_pkg::uop_t   u;
  rtpc_pkg::small_t sm_cur;
  rtpc_pkg::wide_t  mc_cur, acc_base, xsrc, ysrc, ux, uy, res;
  rtpc_pkg::wide_t  nt16, nu30, nv30, au30;
  rtpc_pkg::digit_t digit;
  rtpc_pkg::unit_ctl_t ctl;
  logic             is_mac, mac_end, wr_en, hit_w, near_w;

  // edge vectors and ray offset
  assign e1_x = rtpc_pkg::ediff_t'(t1_x) - rtpc_pkg::ediff_t'(t0_x);
  assign e1_y = rtpc_pkg::ediff_t'(t1_y) - rtpc_pkg::ediff_t'(t0_y);
  assign e1_z = rtpc_pkg::ediff_t'(t1_z) - rtpc_pkg::ediff_t'(t0_z);
  assign e2_x = rtpc_pkg::ediff_t'(t2_x) - rtpc_pkg::ediff_t'(t0_x);
  assign e2_y = rtpc_pkg::ediff_t'(t2_y) - rtpc_pkg::ediff_t'(t0_y);
  assign e2_z = rtpc_pkg::ediff_t'(t2_z) - rtpc_pkg::ediff_t'(t0_z);
  assign s_x  = rtpc_pkg::ediff_t'(origin_x) - rtpc_pkg::ediff_t'(t0_x);
  assign s_y  = rtpc_pkg::ediff_t'(origin_y) - rtpc_pkg::ediff_t'(t0_y);
  assign s_z  = rtpc_pkg::ediff_t'(origin_z) - rtpc_pkg::ediff_t'(t0_z);

  // fixed scalings for the bound checks
  assign nt16 = {nt[W-1-rtpc_pkg::COORD_FRAC:0], {rtpc_pkg::COORD_FRAC{1'b0}}};
  assign nu30 = {nu[W-1-rtpc_pkg::BARY_FRAC:0], {rtpc_pkg::BARY_FRAC{1'b0}}};
  assign nv30 = {nv[W-1-rtpc_pkg::BARY_FRAC:0], {rtpc_pkg::BARY_FRAC{1'b0}}};
  assign au30 = {au[W-1-rtpc_pkg::BARY_FRAC:0], {rtpc_pkg::BARY_FRAC{1'b0}}};

  function automatic rtpc_pkg::small_t spick(input rtpc_pkg::ssel_t s);
    rtpc_pkg::small_t r;
    case (s)
      rtpc_pkg::S_E1X:  r = rtpc_pkg::small_t'(e1_x);
      rtpc_pkg::S_E1Y:  r = rtpc_pkg::small_t'(e1_y);
      rtpc_pkg::S_E1Z:  r = rtpc_pkg::small_t'(e1_z);
      rtpc_pkg::S_E2X:  r = rtpc_pkg::small_t'(e2_x);
      rtpc_pkg::S_E2Y:  r = rtpc_pkg::small_t'(e2_y);
      rtpc_pkg::S_E2Z:  r = rtpc_pkg::small_t'(e2_z);
      rtpc_pkg::S_SX:   r = rtpc_pkg::small_t'(s_x);
      rtpc_pkg::S_SY:   r = rtpc_pkg::small_t'(s_y);
      rtpc_pkg::S_SZ:   r = rtpc_pkg::small_t'(s_z);
      rtpc_pkg::S_DX:   r = rtpc_pkg::small_t'(dir_x);
      rtpc_pkg::S_DY:   r = rtpc_pkg::small_t'(dir_y);
      rtpc_pkg::S_DZ:   r = rtpc_pkg::small_t'(dir_z);
      rtpc_pkg::S_MAXD: r = rtpc_pkg::small_t'(ray_limit);
      rtpc_pkg::S_MARG: r = rtpc_pkg::small_t'(edge_margin);
      default:          r = '0;
    endcase
    return r;
  endfunction

  function automatic rtpc_pkg::wide_t wpick(input rtpc_pkg::wsel_t s);
    rtpc_pkg::wide_t r;
    case (s)
      rtpc_pkg::W_E1X:  r = rtpc_pkg::wide_t'(e1_x);
      rtpc_pkg::W_E1Y:  r = rtpc_pkg::wide_t'(e1_y);
      rtpc_pkg::W_E1Z:  r = rtpc_pkg::wide_t'(e1_z);
      rtpc_pkg::W_E2X:  r = rtpc_pkg::wide_t'(e2_x);
      rtpc_pkg::W_E2Y:  r = rtpc_pkg::wide_t'(e2_y);
      rtpc_pkg::W_E2Z:  r = rtpc_pkg::wide_t'(e2_z);
      rtpc_pkg::W_H0:   r = rtpc_pkg::wide_t'(h0);
      rtpc_pkg::W_H1:   r = rtpc_pkg::wide_t'(h1);
      rtpc_pkg::W_H2:   r = rtpc_pkg::wide_t'(h2);
      rtpc_pkg::W_Q0:   r = rtpc_pkg::wide_t'(q0);
      rtpc_pkg::W_Q1:   r = rtpc_pkg::wide_t'(q1);
      rtpc_pkg::W_Q2:   r = rtpc_pkg::wide_t'(q2);
      rtpc_pkg::W_A:    r = det;
      rtpc_pkg::W_NU:   r = nu;
      rtpc_pkg::W_NV:   r = nv;
      rtpc_pkg::W_NT:   r = nt;
      rtpc_pkg::W_UV:   r = uv;
      rtpc_pkg::W_MDA:  r = mda;
      rtpc_pkg::W_MA:   r = ma;
      rtpc_pkg::W_NT16: r = nt16;
      rtpc_pkg::W_NU30: r = nu30;
      rtpc_pkg::W_NV30: r = nv30;
      rtpc_pkg::W_AU30: r = au30;
      rtpc_pkg::W_NUM:  r = num;
      rtpc_pkg::W_DV:   r = dv;
      default:          r = '0;
    endcase
    return r;
  endfunction

  // current micro-op and operand steering
  assign u       = rtpc_pkg::prog(pc);
  assign is_mac  = (u.op == rtpc_pkg::OP_MAC);
  assign mac_end = (dcnt == rtpc_pkg::DCW'(rtpc_pkg::DIG - 1));

  always_comb begin
    xsrc     = wpick(u.xs);
    ysrc     = wpick(u.ys);
    sm_cur   = (dcnt == '0) ? spick(u.ss) : sm;
    mc_cur   = (dcnt == '0) ? ysrc : mc;
    acc_base = (u.clr && dcnt == '0) ? '0 : acc;
    // low digits unsigned, top digit carries the sign
    digit    = mac_end ? {sm_cur[3], sm_cur[3:0]} : {1'b0, sm_cur[3:0]};
    ux       = is_mac ? acc_base : xsrc;
    uy       = is_mac ? mc_cur : ysrc;
    ctl.mac  = is_mac;
    ctl.sub  = is_mac ? (u.sub ^ (u.fix & aneg)) : u.sub;
    wr_en    = (state == ST_RUN) &&
               ((is_mac && mac_end) || (u.op == rtpc_pkg::OP_ADD));
  end

  rtpc_unit u_unit (
    .ctl   (ctl),
    .x     (ux),
    .y     (uy),
    .digit (digit),
    .res   (res)
  );

  // final decision from the stored sums and sign flags
  assign hit_w  = (|det) & ~nu[W-1] & ~f_anu & ~nv[W-1] & ~au[W-1] &
                  ~nt[W-1] & (|nt) & ~f_t;
  assign near_w = f_nu | f_nv | f_au;

  assign in_stall = (state != ST_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      origin_z    <= '0;
      dir_x       <= CW'(1 << rtpc_pkg::COORD_FRAC);
      dir_y       <= '0;
      dir_z       <= '0;
      ray_limit   <= '1;
      edge_margin <= QW'(1);
    end else if (cfg_write) begin
      case (rtpc_pkg::reg_t'(cfg_index))
        rtpc_pkg::R_ORIGIN_X:    origin_x    <= cfg_data;
        rtpc_pkg::R_ORIGIN_Y:    origin_y    <= cfg_data;
        rtpc_pkg::R_ORIGIN_Z:    origin_z    <= cfg_data;
        rtpc_pkg::R_DIR_X:       dir_x       <= cfg_data;
        rtpc_pkg::R_DIR_Y:       dir_y       <= cfg_data;
        rtpc_pkg::R_DIR_Z:       dir_z       <= cfg_data;
        rtpc_pkg::R_RAY_LIMIT:   ray_limit   <= cfg_data[QW-1:0];
        rtpc_pkg::R_EDGE_MARGIN: edge_margin <= cfg_data[QW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      dcnt      <= '0;
      qcnt      <= '0;
      out_valid <= 1'b0;
      parity    <= 1'b0;
      edge_flag <= 1'b0;
      aneg      <= 1'b0;
    end else begin
      // output taken; in ST_DONE the reload below decides instead
      if (out_valid && !out_stall && state != ST_DONE) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            t0_x <= v0_x; t0_y <= v0_y; t0_z <= v0_z;
            t1_x <= v1_x; t1_y <= v1_y; t1_z <= v1_z;
            t2_x <= v2_x; t2_y <= v2_y; t2_z <= v2_z;
            last  <= last_triangle;
            pc    <= '0;
            dcnt  <= '0;
            state <= ST_RUN;
          end
        end

        ST_RUN: begin
          case (u.op)
            rtpc_pkg::OP_MAC: begin
              acc <= res;
              mc  <= mc_cur <<< 4;
              sm  <= sm_cur >>> 4;
              if (mac_end) begin
                dcnt <= '0;
                pc   <= pc + 1'b1;
              end else begin
                dcnt <= dcnt + 1'b1;
              end
            end
            rtpc_pkg::OP_ADD: pc <= pc + 1'b1;
            rtpc_pkg::OP_ABS: begin
              aneg <= det[W-1];
              if (det[W-1]) det <= res;
              pc <= pc + 1'b1;
            end
            rtpc_pkg::OP_DINIT: begin
              num  <= nt16;
              dv   <= det <<< rtpc_pkg::BARY_FRAC;
              qcnt <= '0;
              pc   <= pc + 1'b1;
            end
            rtpc_pkg::OP_DIV: begin
              // restoring step, one quotient bit per cycle
              if (!res[W-1]) num <= res;
              tq   <= {tq[QW-2:0], ~res[W-1]};
              dv   <= dv >>> 1;
              qcnt <= qcnt + 1'b1;
              if (qcnt == rtpc_pkg::QCW'(QW - 1)) pc <= pc + 1'b1;
            end
            default: state <= ST_DONE;
          endcase

          if (wr_en) begin
            case (u.dst)
              rtpc_pkg::D_H0:   h0    <= res[rtpc_pkg::HQW-1:0];
              rtpc_pkg::D_H1:   h1    <= res[rtpc_pkg::HQW-1:0];
              rtpc_pkg::D_H2:   h2    <= res[rtpc_pkg::HQW-1:0];
              rtpc_pkg::D_Q0:   q0    <= res[rtpc_pkg::HQW-1:0];
              rtpc_pkg::D_Q1:   q1    <= res[rtpc_pkg::HQW-1:0];
              rtpc_pkg::D_Q2:   q2    <= res[rtpc_pkg::HQW-1:0];
              rtpc_pkg::D_A:    det   <= res;
              rtpc_pkg::D_NU:   nu    <= res;
              rtpc_pkg::D_NV:   nv    <= res;
              rtpc_pkg::D_NT:   nt    <= res;
              rtpc_pkg::D_UV:   uv    <= res;
              rtpc_pkg::D_AU:   au    <= res;
              rtpc_pkg::D_MDA:  mda   <= res;
              rtpc_pkg::D_MA:   ma    <= res;
              rtpc_pkg::D_FANU: f_anu <= res[W-1];
              rtpc_pkg::D_FT:   f_t   <= res[W-1];
              rtpc_pkg::D_FNU:  f_nu  <= res[W-1];
              rtpc_pkg::D_FNV:  f_nv  <= res[W-1];
              rtpc_pkg::D_FAU:  f_au  <= res[W-1];
              default: ;
            endcase
          end
        end

        ST_DONE: begin
          // hand the item over once the output register is free
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            hit           <= hit_w;
            hit_distance  <= hit_w ? tq : '0;
            near_edge     <= hit_w & near_w;
            inside_parity <= parity ^ hit_w;
            edge_seen     <= edge_flag | (hit_w & near_w);
            is_last       <= last;
            parity        <= last ? 1'b0 : (parity ^ hit_w);
            edge_flag     <= last ? 1'b0 : (edge_flag | (hit_w & near_w));
            state         <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/rtpc_checker.sv =====
// Port-level checks for the ray/triangle parity counter, bound to the top level.
module rtpc_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    hit,
  input logic [rtpc_pkg::QW-1:0] hit_distance,
  input logic                    near_edge,
  input logic                    edge_seen
);

  // a missed triangle reports no distance and no edge
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (hit_distance == '0 && !near_edge))
    else $error("miss with nonzero distance or edge flag");

  // near edge only on a hit
  a_near_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && near_edge) |-> hit)
    else $error("near_edge without hit");

  // sticky flag covers the current item
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && near_edge) |-> edge_seen)
    else $error("edge_seen low on a near-edge hit");

  // an accepted item keeps the unit busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting an item");

endmodule

bind ray_triangle_parity_counter rtpc_checker u_rtpc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .hit          (hit),
  .hit_distance (hit_distance),
  .near_edge    (near_edge),
  .edge_seen    (edge_seen)
);
